@@ rtl/core/imhuq_pkg.sv @@
package imhuq_pkg;

  localparam int ID_W         = 11;
  localparam int KEY_W        = 32;
  localparam int ID_COUNT     = 1024;
  localparam int ID_AW        = 10;
  localparam int HEAP_CAPACITY = 1024;

  typedef enum logic [1:0] {
    MODE_APPEND   = 2'd0,
    MODE_CHANGE   = 2'd1,
    MODE_QUERY    = 2'd2,
    MODE_RESERVED = 2'd3
  } mode_t;

  typedef enum logic {
    STATUS_OK    = 1'b0,
    STATUS_EMPTY = 1'b1
  } status_t;

  typedef struct packed {
    logic [1:0]              mode;
    logic [ID_W-1:0]         element_id;
    logic signed [KEY_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0]         min_id;
    logic signed [KEY_W-1:0] min_value;
    logic                    status;
  } rsp_t;

  // one heap slot: key and owning id
  typedef struct packed {
    logic signed [KEY_W-1:0] value;
    logic [ID_W-1:0]         owner;
  } ent_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MAPRD,
    S_CHKRD,
    S_CHK,
    S_UP,
    S_UPCMP,
    S_DN,
    S_DNC1,
    S_DNC2,
    S_DNCMP,
    S_FIN,
    S_QRD,
    S_QOUT
  } state_t;

  // strict heap order: key first, smaller id wins a tie
  function automatic logic ent_less(input ent_t a, input ent_t b);
    if (a.value == b.value) begin
      return a.owner < b.owner;
    end
    return a.value < b.value;
  endfunction

endpackage

@@ rtl/core/indexed_min_heap_update_query.sv @@
// Query: an empty heap answers from idle; otherwise the root is read (S_QRD, S_QOUT) before the result strobe.
// Append: the new entry climbs one level per parent read and compare (S_UP, S_UPCMP).
// Change: map read, slot check, then sift up and down, paced by the single heap read port.
// One item at a time; busy stays high until the item is finished.
// Reset (rst, synchronous): heap becomes empty; slot stores keep stale contents.
// The result receiver cannot stall: result_valid is a one-cycle strobe.
module indexed_min_heap_update_query #(
  parameter int CAPACITY = imhuq_pkg::HEAP_CAPACITY
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  imhuq_pkg::req_t request,
  output logic            result_valid,
  output imhuq_pkg::rsp_t result
);
  import imhuq_pkg::*;

  localparam int SW = $clog2(CAPACITY + 1);  // slot numbers 1..CAPACITY
  localparam int AW = $clog2(CAPACITY);      // memory addresses 0..CAPACITY-1
  localparam logic [SW-1:0] CAP_SLOTS = SW'(CAPACITY);

  state_t state, state_next;

  // heap slot store and id-to-slot map
  ent_t          heap_mem [CAPACITY];
  logic [SW-1:0] map_mem  [ID_COUNT];
  ent_t          rd;      // registered heap read data
  logic [SW-1:0] map_q;   // registered map read data

  logic [SW-1:0]   count;
  logic [SW-1:0]   s;     // slot currently held by the moving entry
  logic [SW:0]     c;     // chosen child slot
  ent_t            cur;   // moving entry, written back once at the end
  ent_t            ch;    // best child seen so far
  logic            is_chg;
  logic [ID_W-1:0] req_id;

  // control from the sequencer
  logic          heap_we;
  logic [AW-1:0] heap_wa, heap_ra;
  ent_t          heap_wd;
  logic          map_we;
  logic [ID_AW-1:0] map_wa, map_ra;
  logic [SW-1:0] map_wd;

  // shared comparator
  ent_t cmp_a, cmp_b;
  logic lt;

  logic          id_ok;
  logic [SW:0]   s2;
  logic [SW-1:0] s_half;

  assign id_ok  = (request.element_id != '0) && (request.element_id <= ID_W'(ID_COUNT));
  assign s2     = {s, 1'b0};
  assign s_half = s >> 1;
  assign lt     = ent_less(cmp_a, cmp_b);
  assign busy   = (state != S_IDLE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (request.mode)
            MODE_APPEND: if (id_ok && count < CAP_SLOTS) state_next = S_UP;
            MODE_CHANGE: if (id_ok) state_next = S_MAPRD;
            MODE_QUERY:  if (count != '0) state_next = S_QRD;
            default:     state_next = S_IDLE;
          endcase
        end
      end
      S_MAPRD: state_next = S_CHKRD;
      S_CHKRD: state_next = S_CHK;
      S_CHK: begin
        if (s != '0 && s <= count && rd.owner == req_id) state_next = S_UP;
        else state_next = S_IDLE;
      end
      S_UP: begin
        if (s == SW'(1)) state_next = is_chg ? S_DN : S_FIN;
        else state_next = S_UPCMP;
      end
      S_UPCMP: begin
        if (lt) state_next = S_UP;
        else state_next = is_chg ? S_DN : S_FIN;
      end
      S_DN: begin
        if (s <= (count >> 1)) state_next = S_DNC1;
        else state_next = S_FIN;
      end
      S_DNC1: begin
        if ({s, 1'b1} <= {1'b0, count}) state_next = S_DNC2;
        else state_next = S_DNCMP;
      end
      S_DNC2:  state_next = S_DNCMP;
      S_DNCMP: state_next = lt ? S_FIN : S_DN;
      S_FIN:   state_next = S_IDLE;
      S_QRD:   state_next = S_QOUT;
      S_QOUT:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // memory ports and comparator operands
  always_comb begin
    heap_we = 1'b0;
    heap_wa = '0;
    heap_wd = cur;
    heap_ra = '0;
    map_we  = 1'b0;
    map_wa  = '0;
    map_wd  = s;
    map_ra  = ID_AW'(req_id - ID_W'(1));
    cmp_a   = cur;
    cmp_b   = rd;
    case (state)
      S_CHKRD: heap_ra = AW'(map_q - SW'(1));
      S_UP:    heap_ra = AW'(s_half - SW'(1));
      S_UPCMP: begin
        // parent moves down into the hole
        heap_we = lt;
        heap_wa = AW'(s - SW'(1));
        heap_wd = rd;
        map_we  = lt;
        map_wa  = ID_AW'(rd.owner - ID_W'(1));
      end
      S_DN:    heap_ra = AW'(s2 - (SW+1)'(1));
      S_DNC1:  heap_ra = AW'(s2);
      S_DNC2: begin
        cmp_a = rd;
        cmp_b = ch;
      end
      S_DNCMP: begin
        // child moves up into the hole
        cmp_b   = ch;
        heap_we = !lt;
        heap_wa = AW'(s - SW'(1));
        heap_wd = ch;
        map_we  = !lt;
        map_wa  = ID_AW'(ch.owner - ID_W'(1));
      end
      S_FIN: begin
        heap_we = 1'b1;
        heap_wa = AW'(s - SW'(1));
        heap_wd = cur;
        map_we  = 1'b1;
        map_wa  = ID_AW'(cur.owner - ID_W'(1));
      end
      default: heap_ra = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (heap_we) heap_mem[heap_wa] <= heap_wd;
    rd <= heap_mem[heap_ra];
    if (map_we) map_mem[map_wa] <= map_wd;
    map_q <= map_mem[map_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            req_id <= request.element_id;
            cur    <= '{value: request.value, owner: request.element_id};
            is_chg <= (request.mode == MODE_CHANGE);
            if (request.mode == MODE_APPEND && id_ok && count < CAP_SLOTS) begin
              count <= count + SW'(1);
              s     <= count + SW'(1);
            end
            if (request.mode == MODE_QUERY && count == '0) begin
              // empty heap: report at once
              result       <= '{min_id: '0, min_value: '0, status: STATUS_EMPTY};
              result_valid <= 1'b1;
            end
          end
        end
        S_CHKRD: s <= map_q;
        S_UPCMP: if (lt) s <= s_half;
        S_DNC1: begin
          ch <= rd;
          c  <= s2;
        end
        S_DNC2: begin
          // right child wins only when strictly smaller
          if (lt) begin
            ch <= rd;
            c  <= {s, 1'b1};
          end
        end
        S_DNCMP: if (!lt) s <= SW'(c);
        S_QOUT: begin
          result       <= '{min_id: rd.owner, min_value: rd.value, status: STATUS_OK};
          result_valid <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // heap never grows past its slots
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_SLOTS)
    else $error("entry count beyond capacity");

  // a non-empty query walks to the read state
  a_query_path: assert property (@(posedge clk) disable iff (rst)
    start && !busy && request.mode == MODE_QUERY && count != '0 |=> state == S_QRD)
    else $error("query did not start heap read");

  // sifting always works on a real slot
  a_slot_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_UP || state == S_DN || state == S_FIN |-> s != '0 && s <= count)
    else $error("sift slot out of range");

  // empty status carries id zero
  a_empty_id: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == STATUS_EMPTY |-> result.min_id == '0)
    else $error("empty result with nonzero id");

endmodule

@@ verif/tb_indexed_min_heap_update_query.sv @@
`timescale 1ns / 1ps

module tb_indexed_min_heap_update_query;
  import imhuq_pkg::*;

  localparam int CAP = HEAP_CAPACITY;
  localparam int TAIL_CYCLES = 200;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  req_t request = '0;
  logic result_valid;
  rsp_t result;

  indexed_min_heap_update_query dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .result_valid(result_valid),
    .result(result)
  );

  always #1 clk = ~clk;

  // heap mirror, 1-based slots
  logic signed [KEY_W-1:0] heap_key [1:CAP];
  logic [ID_W-1:0]         heap_id  [1:CAP];
  int unsigned             pos_of_id [1:ID_COUNT];
  bit                      id_seen  [1:ID_COUNT];
  int unsigned             fill;
  int unsigned             gen_fill = 0;

  req_t pending_items [$];
  rsp_t expected_minimums [$];
  int   error_count = 0;
  bit   stim_done = 1'b0;
  bit   hold_sender = 1'b0;
  bit   quiet_sender = 1'b0;
  bit   accepted_last = 1'b0;

  function automatic bit slot_before(int unsigned a, int unsigned b);
    if (heap_key[a] == heap_key[b]) return heap_id[a] < heap_id[b];
    return heap_key[a] < heap_key[b];
  endfunction

  function automatic void swap_slot(int unsigned a, int unsigned b);
    logic signed [KEY_W-1:0] k;
    logic [ID_W-1:0] o;
    k = heap_key[a]; heap_key[a] = heap_key[b]; heap_key[b] = k;
    o = heap_id[a]; heap_id[a] = heap_id[b]; heap_id[b] = o;
    if (heap_id[a] >= 1 && heap_id[a] <= ID_COUNT) pos_of_id[heap_id[a]] = a;
    if (heap_id[b] >= 1 && heap_id[b] <= ID_COUNT) pos_of_id[heap_id[b]] = b;
  endfunction

  function automatic int unsigned climb(int unsigned s);
    while (s > 1 && slot_before(s, s >> 1)) begin
      swap_slot(s, s >> 1);
      s = s >> 1;
    end
    return s;
  endfunction

  function automatic void descend(int unsigned s);
    int unsigned c;
    while (s <= fill / 2) begin
      c = s * 2;
      if (c + 1 <= fill && slot_before(c + 1, c)) c++;
      if (slot_before(s, c)) break;
      swap_slot(s, c);
      s = c;
    end
  endfunction

  // apply one accepted item to the mirror; queue the minimum a query yields
  function automatic void predict_heap(req_t it);
    int unsigned s;
    rsp_t r;
    case (it.mode)
      MODE_APPEND: begin
        if (it.element_id >= 1 && it.element_id <= ID_COUNT && fill < CAP) begin
          fill++;
          heap_key[fill] = it.value;
          heap_id[fill] = it.element_id;
          pos_of_id[it.element_id] = fill;
          s = climb(fill);
        end
      end
      MODE_CHANGE: begin
        if (it.element_id >= 1 && it.element_id <= ID_COUNT) begin
          s = pos_of_id[it.element_id];
          if (s >= 1 && s <= fill && heap_id[s] == it.element_id) begin
            heap_key[s] = it.value;
            s = climb(s);
            descend(s);
          end
        end
      end
      MODE_QUERY: begin
        if (fill == 0) begin
          r.min_id = '0; r.min_value = '0; r.status = STATUS_EMPTY;
        end else begin
          r.min_id = heap_id[1]; r.min_value = heap_key[1]; r.status = STATUS_OK;
        end
        expected_minimums.push_back(r);
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
    error_count++;
  endtask

  // keep the generator's view of the map in step so a change never
  // touches an id that was never stored; appends past capacity store nothing
  task automatic queue_item(input logic [1:0] m, input int id, input logic [31:0] v);
    req_t it;
    it.mode = m;
    it.element_id = id[ID_W-1:0];
    it.value = v;
    if (m == MODE_CHANGE && id >= 1 && id <= ID_COUNT && !id_seen[id]) it.mode = MODE_QUERY;
    if (it.mode == MODE_APPEND && id >= 1 && id <= ID_COUNT && gen_fill < CAP) begin
      id_seen[id] = 1'b1;
      gen_fill++;
    end
    pending_items.push_back(it);
  endtask

  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 7);
      3: return -$urandom_range(0, 7);
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_id();
    case ($urandom_range(0, 9))
      0: return 1;
      1: return ID_COUNT;
      2: return $urandom_range(0, 2047);
      default: return $urandom_range(1, 24);
    endcase
  endfunction

  // driver: present the next item at the falling edge, hold until accepted
  always @(negedge clk) begin
    if (!rst) begin
      if (!start || accepted_last) begin
        if (pending_items.size() != 0 && !hold_sender &&
            (quiet_sender || $urandom_range(0, 99) >= 6)) begin
          request <= pending_items.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: sample acceptance and result strobes at the rising edge
  always @(posedge clk) begin
    rsp_t want;
    accepted_last <= 1'b0;
    if (!rst) begin
      if (start && !busy) begin
        predict_heap(request);
        accepted_last <= 1'b1;
      end
      if (result_valid) begin
        if (expected_minimums.size() == 0) begin
          report_mismatch("unexpected result", result, 0);
        end else begin
          want = expected_minimums.pop_front();
          if (result.min_id !== want.min_id)
            report_mismatch("min_id", result.min_id, want.min_id);
          if (result.min_value !== want.min_value)
            report_mismatch("min_value", result.min_value, want.min_value);
          if (result.status !== want.status)
            report_mismatch("status", result.status, want.status);
        end
      end
    end
  end

  initial begin
    int m;
    fill = 0;
    for (int i = 1; i <= ID_COUNT; i++) begin
      pos_of_id[i] = 0;
      id_seen[i] = 1'b0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: empty query, extremes, ties, bad ids, reserved mode
    queue_item(MODE_QUERY, 0, 0);
    queue_item(MODE_CHANGE, 0, 5);
    queue_item(MODE_APPEND, 0, 5);
    queue_item(MODE_APPEND, 2047, 5);
    queue_item(MODE_APPEND, 1025, 5);
    queue_item(MODE_QUERY, 0, 0);
    queue_item(MODE_APPEND, ID_COUNT, 32'h7fff_ffff);
    queue_item(MODE_QUERY, 0, 0);
    queue_item(MODE_APPEND, 1, 32'h7fff_ffff);
    queue_item(MODE_QUERY, 0, 0);
    queue_item(MODE_APPEND, 7, 32'h8000_0000);
    queue_item(MODE_APPEND, 3, 32'h8000_0000);
    queue_item(MODE_QUERY, 0, 0);
    queue_item(MODE_CHANGE, 3, 32'h7fff_ffff);
    queue_item(MODE_QUERY, 0, 0);
    queue_item(MODE_APPEND, 7, -1);
    queue_item(MODE_CHANGE, 7, 32'h8000_0000);
    queue_item(MODE_QUERY, 0, 0);
    queue_item(MODE_RESERVED, 5, 1);
    queue_item(MODE_CHANGE, ID_COUNT, 32'h8000_0000);
    queue_item(MODE_QUERY, 2047, 32'hffff_ffff);

    // random: mostly appends and changes of live ids, queries between
    for (int n = 0; n < 520; n++) begin
      m = $urandom_range(0, 99);
      if (m < 35) queue_item(MODE_APPEND, pick_id(), pick_key());
      else if (m < 65) queue_item(MODE_CHANGE, pick_id(), pick_key());
      else if (m < 95) queue_item(MODE_QUERY, $urandom_range(0, 2047), $urandom);
      else queue_item(MODE_RESERVED, $urandom_range(0, 2047), $urandom);
    end

    // close with changes each checked by a query
    for (int n = 0; n < 30; n++) begin
      if ($urandom_range(0, 1)) queue_item(MODE_CHANGE, pick_id(), pick_key());
      queue_item(MODE_QUERY, 0, 0);
    end

    // drain pause partway: stop the sender until all results are in
    wait (pending_items.size() < 400);
    @(negedge clk);
    hold_sender = 1'b1;
    wait (!start && expected_minimums.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    hold_sender = 1'b0;

    // run a stretch without idle gaps
    quiet_sender = 1'b1;
    wait (pending_items.size() < 200);
    quiet_sender = 1'b0;

    wait (pending_items.size() == 0);
    @(posedge clk);
    wait (!start || accepted_last);
    wait (expected_minimums.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/imhuq_pkg.sv
rtl/core/indexed_min_heap_update_query.sv
verif/tb_indexed_min_heap_update_query.sv
